@@ src/tclr_pkg.sv @@
package tclr_pkg;

	// default log size
	localparam int DEF_LOG_DEPTH = 64;

	// operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_EXEC  = 2'd1;
	localparam logic [1:0] OP_UNDO  = 2'd2;
	localparam logic [1:0] OP_ALIGN = 2'd3;

	// result codes
	localparam logic [1:0] RK_NONE  = 2'd0;
	localparam logic [1:0] RK_EXEC  = 2'd1;
	localparam logic [1:0] RK_UNDO  = 2'd2;
	localparam logic [1:0] RK_ALIGN = 2'd3;

	// code byte layout: bank in the top bits, command type below
	localparam int BANK_SHIFT = 5;
	localparam logic [4:0] KIND_MASK = 5'h1F;

	typedef struct packed {
		logic [7:0]  frame;
		logic [7:0]  code;
		logic [15:0] arg;
	} entry_t;

endpackage

@@ src/timed_command_log_replay_core.sv @@
// Frame-stamped command log. An add (operation 0) stores one entry at the
// append position and gives a single empty result in the next cycle; adds to
// a full log are dropped. An execute (1) walks forward from the replay pointer
// and dispatches every consecutive entry stamped with the given frame and bank
// up to the first one of empty type, an undo (2) walks backward from the rewind
// pointer the same way, and an align (3) copies the current pointer into the
// replay pointer and answers with the full frame of the entry under the rewind
// pointer. The log sits in a single-port memory with a registered read, so
// every entry the walk examines passes through a read state and then an
// evaluate state; a walk that ends at the first or last table entry also
// passes through a flush state to send its final dispatch. An add does not
// raise busy. Results leave as one-cycle pulses on result_strobe with
// last_of_run marking the final result of each transaction; the receiver
// cannot hold them off, and every transaction gives at least one result.
// Entries at or beyond the append position read as all zero, so the memory
// needs no clearing pass after reset.
module timed_command_log_replay_core
	import tclr_pkg::*;
#(
	parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [10:0] frame_number,
	input  logic [4:0]  command_kind,
	input  logic [15:0] argument_word,
	output logic        result_strobe,
	output logic [1:0]  result_kind,
	output logic [4:0]  dispatched_kind,
	output logic [15:0] dispatched_argument,
	output logic [10:0] aligned_frame,
	output logic        last_of_run
);

	// pointer width and fill count width
	localparam int PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int AW = $clog2(LOG_DEPTH + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	// log memory, valid below the append position
	entry_t mem [LOG_DEPTH];
	entry_t rd_data_q;
	logic   rd_valid_q;

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	logic [7:0]    fmain_q;
	logic [2:0]    fbank_q;
	logic          first_q;     // no dispatch held yet in this walk
	logic [PW-1:0] addr_q;      // entry under examination
	logic [AW-1:0] append_q;
	logic [PW-1:0] replay_q;
	logic [PW-1:0] rewind_q;
	logic [PW-1:0] cur_q;

	// held dispatch, sent once we know whether it ends the run
	logic [4:0]    pend_kind_q;
	logic [15:0]   pend_arg_q;

	// result registers
	logic          strobe_q;
	logic [1:0]    rk_q;
	logic [4:0]    dk_q;
	logic [15:0]   darg_q;
	logic [10:0]   afr_q;
	logic          last_q;

	entry_t        ent;
	entry_t        new_ent;
	logic          match;
	logic [4:0]    ent_kind;
	logic          full;
	logic          wr_en;
	logic          at_last;
	logic          at_first;
	logic [1:0]    walk_rk;

	assign full     = (append_q == AW'(LOG_DEPTH));
	assign wr_en    = (state_q == ST_IDLE) && start && (operation == OP_ADD) && !full;
	assign new_ent  = '{frame: frame_number[7:0],
	                    code:  {frame_number[10:8], command_kind & KIND_MASK},
	                    arg:   argument_word};

	// entry fields as seen by the walk, zero when never written
	assign ent      = rd_valid_q ? rd_data_q : '0;
	assign ent_kind = ent.code[4:0] & KIND_MASK;
	assign match    = (ent.frame == fmain_q) && (ent.code[7:BANK_SHIFT] == fbank_q);
	assign at_last  = (addr_q == PW'(LOG_DEPTH - 1));
	assign at_first = (addr_q == '0);
	assign walk_rk  = (op_q == OP_EXEC) ? RK_EXEC : RK_UNDO;

	// memory port: write on add, registered read during the read state
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[append_q[PW-1:0]] <= new_ent;
		end
		if (state_q == ST_READ) begin
			rd_data_q  <= mem[addr_q];
			rd_valid_q <= (AW'(addr_q) < append_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ADD;
			fmain_q     <= '0;
			fbank_q     <= '0;
			first_q     <= 1'b1;
			addr_q      <= '0;
			append_q    <= '0;
			replay_q    <= '0;
			rewind_q    <= '0;
			cur_q       <= '0;
			pend_kind_q <= '0;
			pend_arg_q  <= '0;
			strobe_q    <= 1'b0;
			rk_q        <= RK_NONE;
			dk_q        <= '0;
			darg_q      <= '0;
			afr_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// an add answers with an empty result
					strobe_q <= start && (operation == OP_ADD);
					if (start) begin
						op_q    <= operation;
						fmain_q <= frame_number[7:0];
						fbank_q <= frame_number[10:8];
						first_q <= 1'b1;
						if (operation == OP_ADD) begin
							if (!full) begin
								append_q <= append_q + AW'(1);
							end
							rk_q     <= RK_NONE;
							dk_q     <= '0;
							darg_q   <= '0;
							afr_q    <= '0;
							last_q   <= 1'b1;
						end else begin
							addr_q  <= (operation == OP_EXEC) ? replay_q : rewind_q;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					strobe_q <= 1'b0;
					state_q  <= ST_EVAL;
				end
				ST_EVAL: begin
					priority if (op_q == OP_ALIGN) begin
						// report the rewind entry, move replay to current
						strobe_q <= 1'b1;
						rk_q     <= RK_ALIGN;
						dk_q     <= '0;
						darg_q   <= '0;
						afr_q    <= {ent.code[7:BANK_SHIFT], ent.frame};
						last_q   <= 1'b1;
						replay_q <= cur_q;
						state_q  <= ST_IDLE;
					end else if (!match || ent_kind == '0) begin
						// walk ends here; a stamped empty entry sets the pointers
						if (match) begin
							cur_q    <= addr_q;
							rewind_q <= addr_q;
						end
						strobe_q <= 1'b1;
						rk_q     <= first_q ? RK_NONE : walk_rk;
						dk_q     <= first_q ? 5'd0 : pend_kind_q;
						darg_q   <= first_q ? 16'd0 : pend_arg_q;
						afr_q    <= '0;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						// this entry is dispatched; send the held one as not last
						strobe_q    <= !first_q;
						rk_q        <= walk_rk;
						dk_q        <= pend_kind_q;
						darg_q      <= pend_arg_q;
						afr_q       <= '0;
						last_q      <= 1'b0;
						pend_kind_q <= ent_kind;
						pend_arg_q  <= ent.arg;
						first_q     <= 1'b0;
						if (op_q == OP_EXEC) begin
							cur_q    <= addr_q;
							rewind_q <= addr_q;
							if (at_last) begin
								state_q <= ST_FLUSH;
							end else begin
								replay_q <= addr_q + PW'(1);
								addr_q   <= addr_q + PW'(1);
								state_q  <= ST_READ;
							end
						end else begin
							if (at_first) begin
								rewind_q <= '0;
								cur_q    <= '0;
								state_q  <= ST_FLUSH;
							end else begin
								rewind_q <= addr_q - PW'(1);
								cur_q    <= addr_q - PW'(1);
								addr_q   <= addr_q - PW'(1);
								state_q  <= ST_READ;
							end
						end
					end
				end
				ST_FLUSH: begin
					// table edge reached: held dispatch closes the run
					strobe_q <= 1'b1;
					rk_q     <= walk_rk;
					dk_q     <= pend_kind_q;
					darg_q   <= pend_arg_q;
					afr_q    <= '0;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign result_strobe       = strobe_q;
	assign result_kind         = rk_q;
	assign dispatched_kind     = dk_q;
	assign dispatched_argument = darg_q;
	assign aligned_frame       = afr_q;
	assign last_of_run         = last_q;

	// an add is answered on the next cycle with a closing result
	a_add_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_ADD |=> result_strobe && last_of_run)
		else $error("add not answered");

	// the fill count never passes the log size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		append_q <= AW'(LOG_DEPTH))
		else $error("append position beyond log");

	// a flush always has a held dispatch
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !first_q)
		else $error("flush without held dispatch");

	// leaving a walk always closes the run
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_strobe && last_of_run)
		else $error("transaction ended without final result");

	// an empty result is always the only one
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == RK_NONE |-> last_of_run)
		else $error("empty result not final");

endmodule

@@ tb/tb_timed_command_log_replay_core.sv @@
`timescale 1ns / 100ps

// Testbench for the frame-stamped command log. Commands go in over the
// start/busy handshake and are predicted at the edge where they are taken; every
// strobed result is checked field by field against the oldest prediction. The
// run starts with directed commands on an empty log, builds a small log by hand,
// then fills the log with runs of equally stamped entries while replay, undo and
// align walk it. It ends by driving the forward walk into the last table entry,
// poking a full log, and a short random tail with no idle gaps.
module tb_timed_command_log_replay_core;
	import tclr_pkg::*;

	localparam int LOG_DEPTH = DEF_LOG_DEPTH;
	// the drain time allows for a walk over the whole log, its flush included
	localparam int DRAIN_CYCLES = 2 * LOG_DEPTH + 16;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [10:0] frame_number;
	logic [4:0]  command_kind;
	logic [15:0] argument_word;
	logic        result_strobe;
	logic [1:0]  result_kind;
	logic [4:0]  dispatched_kind;
	logic [15:0] dispatched_argument;
	logic [10:0] aligned_frame;
	logic        last_of_run;

	timed_command_log_replay_core #(
		.LOG_DEPTH(LOG_DEPTH)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.operation          (operation),
		.frame_number       (frame_number),
		.command_kind       (command_kind),
		.argument_word      (argument_word),
		.result_strobe      (result_strobe),
		.result_kind        (result_kind),
		.dispatched_kind    (dispatched_kind),
		.dispatched_argument(dispatched_argument),
		.aligned_frame      (aligned_frame),
		.last_of_run        (last_of_run)
	);

	always #10 clk = ~clk;

	// one predicted result of a transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  cmd;
		logic [15:0] arg;
		logic [10:0] frame;
		logic        last;
	} dispatch_t;

	dispatch_t pending_dispatches[$];

	// our own copy of the log and its pointers
	logic [7:0]  log_frame [LOG_DEPTH];
	logic [7:0]  log_code  [LOG_DEPTH];
	logic [15:0] log_arg   [LOG_DEPTH];
	int unsigned fill_count = 0;
	int unsigned replay_at = 0;
	int unsigned rewind_at = 0;
	int unsigned cursor_at = 0;

	bit reached_table_end = 1'b0;
	bit reached_table_start = 1'b0;
	bit gaps_on = 1'b1;
	int transactions_sent = 0;
	int replay_count = 0;
	int undo_count = 0;
	int align_count = 0;
	int empty_count = 0;
	int error_count = 0;
	int cycle_count = 0;

	// pointers past the table end stick at the last entry
	function automatic int unsigned clamp_index(int unsigned i);
		return (i < LOG_DEPTH) ? i : LOG_DEPTH - 1;
	endfunction

	// full 11-bit frame of an entry: bank from the code byte, low bits stored
	function automatic logic [10:0] stamp_of(int unsigned i);
		int unsigned k;
		k = clamp_index(i);
		return {log_code[k][7:BANK_SHIFT], log_frame[k]};
	endfunction

	function automatic bit stamp_matches(int unsigned i, logic [10:0] stamp);
		return stamp_of(i) == stamp;
	endfunction

	// work out every result of one transaction and update the log copy
	function automatic void predict_transaction(logic [1:0] op, logic [10:0] stamp,
			logic [4:0] cmd, logic [15:0] arg);
		dispatch_t r;
		dispatch_t batch[$];
		int unsigned k;
		bit walking;
		case (op)
		OP_ADD: begin
			// adds to a full log are dropped
			if (fill_count < LOG_DEPTH) begin
				log_frame[fill_count] = stamp[7:0];
				log_code[fill_count] = {stamp[10:8], cmd};
				log_arg[fill_count] = arg;
				fill_count++;
			end
		end
		OP_EXEC: begin
			// nothing moves if the starting entry carries another stamp
			if (stamp_matches(replay_at, stamp)) begin
				walking = 1'b1;
				while (walking) begin
					k = clamp_index(replay_at);
					cursor_at = k;
					if (log_code[k][BANK_SHIFT-1:0] == '0) begin
						// empty entry ends the walk without a dispatch
						walking = 1'b0;
					end else begin
						r = '0;
						r.kind = RK_EXEC;
						r.cmd = log_code[k][BANK_SHIFT-1:0];
						r.arg = log_arg[k];
						batch.push_back(r);
						if (k + 1 >= LOG_DEPTH) begin
							// table end: replay pointer stays on the last entry
							walking = 1'b0;
							reached_table_end = 1'b1;
						end else begin
							replay_at = k + 1;
							walking = stamp_matches(replay_at, stamp);
						end
					end
				end
				// undo resumes from the last entry looked at
				rewind_at = cursor_at;
			end
		end
		OP_UNDO: begin
			if (stamp_matches(rewind_at, stamp)) begin
				walking = 1'b1;
				while (walking) begin
					k = clamp_index(rewind_at);
					cursor_at = k;
					if (log_code[k][BANK_SHIFT-1:0] == '0) begin
						walking = 1'b0;
					end else begin
						r = '0;
						r.kind = RK_UNDO;
						r.cmd = log_code[k][BANK_SHIFT-1:0];
						r.arg = log_arg[k];
						batch.push_back(r);
						if (k == 0) begin
							// table start: walk stops after entry zero
							rewind_at = 0;
							walking = 1'b0;
							reached_table_start = 1'b1;
						end else begin
							rewind_at = k - 1;
							walking = stamp_matches(rewind_at, stamp);
						end
					end
				end
				cursor_at = rewind_at;
			end
		end
		OP_ALIGN: begin
			// answer with the undo entry, then move replay to the cursor
			r = '0;
			r.kind = RK_ALIGN;
			r.frame = stamp_of(rewind_at);
			replay_at = clamp_index(cursor_at);
			batch.push_back(r);
		end
		endcase
		if (batch.size() == 0) begin
			r = '0;
			r.kind = RK_NONE;
			batch.push_back(r);
		end
		r = batch.pop_back();
		r.last = 1'b1;
		batch.push_back(r);
		foreach (batch[j]) begin
			case (batch[j].kind)
			RK_EXEC: replay_count++;
			RK_UNDO: undo_count++;
			RK_ALIGN: align_count++;
			RK_NONE: empty_count++;
			endcase
			pending_dispatches.push_back(batch[j]);
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// drive one command at the falling edge and hold it until the block takes it
	task automatic send_command(logic [1:0] op, logic [10:0] stamp, logic [4:0] cmd,
			logic [15:0] arg);
		@(negedge clk);
		start = 1'b1;
		operation = op;
		frame_number = stamp;
		command_kind = cmd;
		argument_word = arg;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_transaction(op, stamp, cmd, arg);
		transactions_sent++;
		// idle burst with junk on the payload while start is low
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start = 1'b0;
			operation = 2'($urandom);
			frame_number = 11'($urandom);
			command_kind = 5'($urandom);
			argument_word = 16'($urandom);
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
	endtask

	// empty log: every entry reads as frame zero with an empty type
	task automatic test_reset_state();
		send_command(OP_EXEC, 11'h000, 5'd0, 16'h0000);
		send_command(OP_UNDO, 11'h000, 5'd0, 16'h0000);
		send_command(OP_ALIGN, 11'h000, 5'd0, 16'h0000);
		send_command(OP_EXEC, 11'h7FF, 5'd31, 16'hFFFF);
	endtask

	// small hand-built log that walks both ways and stops on each condition
	task automatic test_directed_log();
		send_command(OP_ADD, 11'h205, 5'd1, 16'h0000);
		send_command(OP_ADD, 11'h205, 5'd31, 16'hFFFF);
		send_command(OP_ADD, 11'h7FF, 5'd17, 16'hA5A5);
		send_command(OP_EXEC, 11'h205, 5'd0, 16'h0000);
		// same low frame, other bank: no match at the start
		send_command(OP_EXEC, 11'h105, 5'd0, 16'h0000);
		// backward down to entry zero
		send_command(OP_UNDO, 11'h205, 5'd0, 16'h0000);
		send_command(OP_UNDO, 11'h7FF, 5'd0, 16'h0000);
		send_command(OP_EXEC, 11'h7FF, 5'd0, 16'h0000);
		// walks into the unwritten entry and stops on its empty type
		send_command(OP_EXEC, 11'h000, 5'd0, 16'h0000);
		send_command(OP_ALIGN, 11'h7FF, 5'd31, 16'hFFFF);
		send_command(OP_UNDO, 11'h205, 5'd0, 16'h0000);
		send_command(OP_ADD, 11'h0AA, 5'd10, 16'h8001);
		send_command(OP_EXEC, 11'h0AA, 5'd0, 16'h0000);
		send_command(OP_UNDO, 11'h0AA, 5'd0, 16'h0000);
		send_command(OP_ALIGN, 11'h000, 5'd0, 16'h0000);
	endtask

	// runs of equally stamped adds mixed with walks that mostly use the stamp
	// under the pointer, so the walks actually travel through the log
	task automatic test_random_mix(int count);
		logic [10:0] run_stamp;
		int run_left;
		int pick;
		run_stamp = '0;
		run_left = 0;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (fill_count < LOG_DEPTH && pick < 35) begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 6);
					run_stamp = ($urandom_range(0, 3) == 0) ? run_stamp + 11'd1 : 11'($urandom);
				end
				run_left--;
				// written empty types would pin both walks forever, so none here
				send_command(OP_ADD, run_stamp, 5'($urandom_range(1, 31)), 16'($urandom));
			end else if (pick < 65) begin
				send_command(OP_EXEC,
					($urandom_range(0, 3) != 0) ? stamp_of(replay_at) : 11'($urandom),
					5'($urandom), 16'($urandom));
			end else if (pick < 88) begin
				send_command(OP_UNDO,
					($urandom_range(0, 3) != 0) ? stamp_of(rewind_at) : 11'($urandom),
					5'($urandom), 16'($urandom));
			end else begin
				send_command(OP_ALIGN, 11'($urandom), 5'($urandom), 16'($urandom));
			end
		end
	endtask

	// fill the log, then replay until the forward walk dispatches the last entry
	task automatic test_table_end();
		logic [10:0] stamp;
		int tries;
		while (fill_count < LOG_DEPTH) begin
			stamp = 11'($urandom);
			repeat ($urandom_range(1, 6))
				send_command(OP_ADD, stamp, 5'($urandom_range(1, 31)), 16'($urandom));
		end
		tries = 0;
		while (!reached_table_end && tries < 2 * LOG_DEPTH) begin
			send_command(OP_EXEC, stamp_of(replay_at), 5'($urandom), 16'($urandom));
			tries++;
		end
		// replay pointer sits on the last entry and replays it again
		send_command(OP_EXEC, stamp_of(replay_at), 5'd0, 16'h0000);
	endtask

	// adds to a full log change nothing, empty type included
	task automatic test_full_log();
		send_command(OP_ADD, 11'h7FF, 5'd0, 16'hFFFF);
		send_command(OP_ADD, 11'h000, 5'd0, 16'h0000);
		send_command(OP_ADD, stamp_of(replay_at), 5'd31, 16'h5A5A);
		send_command(OP_ALIGN, 11'h000, 5'd0, 16'h0000);
		send_command(OP_UNDO, stamp_of(rewind_at), 5'd0, 16'h0000);
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		dispatch_t want;
		if (arst_n && result_strobe) begin
			if (pending_dispatches.size() == 0) begin
				report_mismatch("result_kind of unexpected result", result_kind, 0);
			end else begin
				want = pending_dispatches.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", result_kind, want.kind);
				if (dispatched_kind !== want.cmd)
					report_mismatch("dispatched_kind", dispatched_kind, want.cmd);
				if (dispatched_argument !== want.arg)
					report_mismatch("dispatched_argument", dispatched_argument, want.arg);
				if (aligned_frame !== want.frame)
					report_mismatch("aligned_frame", aligned_frame, want.frame);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_timed_command_log_replay_core: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		frame_number = '0;
		command_kind = '0;
		argument_word = '0;
		for (int i = 0; i < LOG_DEPTH; i++) begin
			log_frame[i] = '0;
			log_code[i] = '0;
			log_arg[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_log();
		test_random_mix(230);
		// last part of the run: commands back to back
		gaps_on = 1'b0;
		test_table_end();
		test_full_log();
		test_random_mix(40);

		@(negedge clk);
		start = 1'b0;
		while (pending_dispatches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d transactions: %0d replay, %0d undo, %0d align, %0d empty results",
			transactions_sent, replay_count, undo_count, align_count, empty_count);
		$display("log filled to %0d entries, table end reached %0d, entry zero reached %0d",
			fill_count, reached_table_end, reached_table_start);
		if (error_count == 0) begin
			$display("tb_timed_command_log_replay_core: clean");
		end else begin
			$display("tb_timed_command_log_replay_core: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/tclr_pkg.sv
src/timed_command_log_replay_core.sv
tb/tb_timed_command_log_replay_core.sv
